[rtl/gfalu_pkg.sv]
// shared types, constants and field arithmetic helpers for the gf(2^128) alu
`timescale 1ns / 1ps

package gfalu_pkg;

  localparam int FIELD_W  = 128;
  localparam int HALF_W   = 64;
  localparam int DIGIT_W  = 16;
  localparam int DIGITS   = FIELD_W / DIGIT_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int OV_SHIFT = 57;
  localparam int NSQ_W    = 6;
  localparam int STEP_W   = 4;

  typedef logic [FIELD_W-1:0] fe_t;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_SQR = 2'd1,
    CMD_INV = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MSTART,
    ST_MWAIT,
    ST_WB
  } state_t;

  typedef enum logic [1:0] {
    OP_T1,
    OP_PRE,
    OP_T7,
    OP_B
  } mul_sel_t;

  typedef struct packed {
    logic [NSQ_W-1:0] nsq;
    mul_sel_t         sel;
    logic             save_t7;
    logic             last;
  } inv_step_t;

  // itoh-tsujii chain for a^(2^128-2): square nsq times, then multiply, except on the last step
  function automatic inv_step_t inv_step(input logic [STEP_W-1:0] idx);
    inv_step_t s;
    s = '{nsq: NSQ_W'(1), sel: OP_T1, save_t7: 1'b0, last: 1'b0};
    case (idx)
      4'd0:    s = '{nsq: NSQ_W'(1),  sel: OP_T1,  save_t7: 1'b0, last: 1'b0};
      4'd1:    s = '{nsq: NSQ_W'(1),  sel: OP_T1,  save_t7: 1'b0, last: 1'b0};
      4'd2:    s = '{nsq: NSQ_W'(3),  sel: OP_PRE, save_t7: 1'b0, last: 1'b0};
      4'd3:    s = '{nsq: NSQ_W'(1),  sel: OP_T1,  save_t7: 1'b1, last: 1'b0};
      4'd4:    s = '{nsq: NSQ_W'(7),  sel: OP_PRE, save_t7: 1'b0, last: 1'b0};
      4'd5:    s = '{nsq: NSQ_W'(14), sel: OP_PRE, save_t7: 1'b0, last: 1'b0};
      4'd6:    s = '{nsq: NSQ_W'(28), sel: OP_PRE, save_t7: 1'b0, last: 1'b0};
      4'd7:    s = '{nsq: NSQ_W'(7),  sel: OP_T7,  save_t7: 1'b0, last: 1'b0};
      4'd8:    s = '{nsq: NSQ_W'(63), sel: OP_PRE, save_t7: 1'b0, last: 1'b0};
      4'd9:    s = '{nsq: NSQ_W'(1),  sel: OP_T1,  save_t7: 1'b0, last: 1'b0};
      4'd10:   s = '{nsq: NSQ_W'(1),  sel: OP_T1,  save_t7: 1'b0, last: 1'b1};
      default: s = '{nsq: NSQ_W'(1),  sel: OP_T1,  save_t7: 1'b0, last: 1'b1};
    endcase
    return s;
  endfunction

  // bit i of x to bit 2i
  function automatic logic [2*HALF_W-1:0] spread64(input logic [HALF_W-1:0] x);
    logic [2*HALF_W-1:0] r;
    r = '0;
    for (int i = 0; i < HALF_W; i++) begin
      r[2*i] = x[i];
    end
    return r;
  endfunction

  // fold a 256-bit word w3:w2:w1:w0 back into the field
  function automatic fe_t reduce256(input logic [HALF_W-1:0] w0, input logic [HALF_W-1:0] w1,
                                    input logic [HALF_W-1:0] w2, input logic [HALF_W-1:0] w3);
    logic [HALF_W-1:0] fl;
    logic [HALF_W-1:0] fh;
    logic [HALF_W-1:0] ov;
    logic [HALF_W-1:0] corr;
    fl = w2 ^ (w2 << 1) ^ (w2 << 2) ^ (w2 << 7);
    fh = w3 ^ {w3[HALF_W-2:0], w2[HALF_W-1]}
            ^ {w3[HALF_W-3:0], w2[HALF_W-1:HALF_W-2]}
            ^ {w3[OV_SHIFT-1:0], w2[HALF_W-1:OV_SHIFT]};
    ov = (w3 >> (HALF_W-1)) ^ (w3 >> (HALF_W-2)) ^ (w3 >> OV_SHIFT);
    corr = ov ^ (ov << 1) ^ (ov << 2) ^ (ov << 7);
    return {w1 ^ fh, w0 ^ fl ^ corr};
  endfunction

  // one msb-first digit step: acc * x^16 + a * d, reduced
  function automatic fe_t mul_digit(input fe_t acc, input fe_t a, input logic [DIGIT_W-1:0] d);
    logic [FIELD_W+DIGIT_W-1:0] t;
    logic [DIGIT_W-1:0]         top;
    logic [DIGIT_W+7-1:0]       fold;
    t = {acc, {DIGIT_W{1'b0}}};
    for (int j = 0; j < DIGIT_W; j++) begin
      if (d[j]) begin
        t = t ^ ({{DIGIT_W{1'b0}}, a} << j);
      end
    end
    top  = t[FIELD_W+DIGIT_W-1:FIELD_W];
    fold = {7'b0, top} ^ ({7'b0, top} << 1) ^ ({7'b0, top} << 2) ^ ({7'b0, top} << 7);
    return t[FIELD_W-1:0] ^ {{(FIELD_W-DIGIT_W-7){1'b0}}, fold};
  endfunction

endpackage

[rtl/gfalu_sqr.sv]
// gf(2^128) squarer: bit spread followed by polynomial reduction
`timescale 1ns / 1ps

module gfalu_sqr import gfalu_pkg::*; (
  input  fe_t a,
  output fe_t sq
);

  logic [2*HALF_W-1:0] sp_lo;
  logic [2*HALF_W-1:0] sp_hi;

  assign sp_lo = spread64(a[HALF_W-1:0]);
  assign sp_hi = spread64(a[FIELD_W-1:HALF_W]);
  assign sq    = reduce256(sp_lo[HALF_W-1:0], sp_lo[2*HALF_W-1:HALF_W],
                           sp_hi[HALF_W-1:0], sp_hi[2*HALF_W-1:HALF_W]);

endmodule

[rtl/gfalu_mul.sv]
// digit-serial gf(2^128) multiplier, 16 bits of b per cycle, msb first
`timescale 1ns / 1ps

module gfalu_mul import gfalu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  fe_t  a,
  input  fe_t  b,
  output logic done,
  output fe_t  prod
);

  fe_t               acc_r, acc_nxt;
  fe_t               a_r, a_nxt;
  fe_t               b_r, b_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      a_nxt   = a;
      b_nxt   = b;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = mul_digit(acc_r, a_r, b_r[FIELD_W-1:FIELD_W-DIGIT_W]);
      b_nxt   = b_r << DIGIT_W;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIGITS-1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/gf2_128_ghash_field_alu.sv]
// top level of the gf(2^128) multiply / square / inverse unit
//
//  channel  ports                                      direction  role
//  in       in_valid in_ready in_cmd in_a_* in_b_*     sink       operation and operands
//  out      out_valid out_ready out_res_lo out_res_hi  source     one result per transfer in
//
// one item at a time; in_ready is high only while the sequencer is idle and out of reset
// multiply: accept, start, the digit steps of the multiplier, done, write-back
// square: accept, squarer, write-back; unused selector: accept, write-back of zero
// inverse: 127 squarings and 10 multiplies on the shared units
// reset (synchronous, active low) clears the sequencer and the output valid flag
// a stalled output holds its register; the next result waits in write-back until it frees
`timescale 1ns / 1ps

module gf2_128_ghash_field_alu import gfalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_a_lo,
  input  logic [63:0] in_a_hi,
  input  logic [63:0] in_b_lo,
  input  logic [63:0] in_b_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_res_lo,
  output logic [63:0] out_res_hi
);

  state_t            state_r, state_nxt;
  cmd_e_t            cmd_r, cmd_nxt;
  fe_t               v_r, v_nxt;      // working value
  fe_t               t1_r, t1_nxt;    // operand a
  fe_t               t7_r, t7_nxt;    // a^(2^7-1), reused late in the chain
  fe_t               pre_r, pre_nxt;  // value at the start of the current chain step
  fe_t               b_r, b_nxt;
  fe_t               res_r, res_nxt;
  logic              ov_r, ov_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NSQ_W-1:0]  sqc_r, sqc_nxt;

  inv_step_t         cur_step;
  inv_step_t         next_step;
  fe_t               sq_out;
  fe_t               mul_b;
  fe_t               mul_prod;
  logic              mul_start;
  logic              mul_done;
  logic              in_xfer;
  logic              out_xfer;

  gfalu_sqr u_sqr (
    .a  (v_r),
    .sq (sq_out)
  );

  gfalu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (v_r),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign cur_step  = inv_step(step_r);
  assign next_step = inv_step(step_r + 1'b1);
  // no input transfer is taken while reset is held
  assign in_ready  = (state_r == ST_IDLE) && rst_n;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = ov_r && out_ready;

  // multiplier second operand
  always_comb begin
    mul_b = t1_r;
    if (cmd_r == CMD_MUL) begin
      mul_b = b_r;
    end else begin
      case (cur_step.sel)
        OP_T1:   mul_b = t1_r;
        OP_PRE:  mul_b = pre_r;
        OP_T7:   mul_b = t7_r;
        OP_B:    mul_b = b_r;
        default: mul_b = t1_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    v_nxt     = v_r;
    t1_nxt    = t1_r;
    t7_nxt    = t7_r;
    pre_nxt   = pre_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    step_nxt  = step_r;
    sqc_nxt   = sqc_r;
    mul_start = 1'b0;
    if (out_xfer) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt  = cmd_e_t'(in_cmd);
          v_nxt    = {in_a_hi, in_a_lo};
          t1_nxt   = {in_a_hi, in_a_lo};
          pre_nxt  = {in_a_hi, in_a_lo};
          b_nxt    = {in_b_hi, in_b_lo};
          step_nxt = '0;
          case (cmd_e_t'(in_cmd))
            CMD_MUL: state_nxt = ST_MSTART;
            CMD_SQR: begin
              sqc_nxt   = NSQ_W'(1);
              state_nxt = ST_SQR;
            end
            CMD_INV: begin
              sqc_nxt   = inv_step(STEP_W'(0)).nsq;
              state_nxt = ST_SQR;
            end
            default: begin
              // unused selector gives zero
              v_nxt     = '0;
              state_nxt = ST_WB;
            end
          endcase
        end
      end
      ST_SQR: begin
        v_nxt   = sq_out;
        sqc_nxt = sqc_r - 1'b1;
        if (sqc_r == NSQ_W'(1)) begin
          if (cmd_r == CMD_INV && !cur_step.last) begin
            state_nxt = ST_MSTART;
          end else begin
            state_nxt = ST_WB;
          end
        end
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          v_nxt = mul_prod;
          if (cmd_r == CMD_MUL) begin
            state_nxt = ST_WB;
          end else begin
            if (cur_step.save_t7) begin
              t7_nxt = mul_prod;
            end
            pre_nxt   = mul_prod;
            step_nxt  = step_r + 1'b1;
            sqc_nxt   = next_step.nsq;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_WB: begin
        // wait for the output register to free
        if (!ov_r || out_ready) begin
          res_nxt   = v_r;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      cmd_r   <= CMD_NOP;
      step_r  <= '0;
      sqc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      sqc_r   <= sqc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    t1_r  <= t1_nxt;
    t7_r  <= t7_nxt;
    pre_r <= pre_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
  end

  assign out_valid  = ov_r;
  assign out_res_lo = res_r[HALF_W-1:0];
  assign out_res_hi = res_r[FIELD_W-1:HALF_W];

endmodule
